// ===== hdl/slt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// slt_pkg
// Shared types, codes and character classes for the small-language tokenizer.
// ============================================================================
package slt_pkg;

  localparam int TEXT_MAX_DEF = 63;  // default count of kept token characters
  localparam int TEXT_CAP     = 63;  // ceiling of the text_length field
  localparam int FIFO_DEPTH   = 4;   // token queue depth, power of two

  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_WHILE = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_PUTI  = 64'h0000_0000_6974_7570;
  localparam logic [63:0] KW_PUTC  = 64'h0000_0000_6374_7570;

  typedef enum logic [4:0] {
    KIND_END     = 5'd0,
    KIND_INT     = 5'd1,
    KIND_SYM     = 5'd2,
    KIND_IF      = 5'd3,
    KIND_ELSE    = 5'd4,
    KIND_WHILE   = 5'd5,
    KIND_PUTI    = 5'd6,
    KIND_PUTC    = 5'd7,
    KIND_SEMI    = 5'd8,
    KIND_ASSIGN  = 5'd9,
    KIND_EQ      = 5'd10,
    KIND_AND     = 5'd11,
    KIND_OR      = 5'd12,
    KIND_PLUS    = 5'd13,
    KIND_MINUS   = 5'd14,
    KIND_STAR    = 5'd15,
    KIND_SLASH   = 5'd16,
    KIND_PERCENT = 5'd17,
    KIND_LT      = 5'd18,
    KIND_LE      = 5'd19,
    KIND_GT      = 5'd20,
    KIND_GE      = 5'd21,
    KIND_LPAREN  = 5'd22,
    KIND_RPAREN  = 5'd23,
    KIND_LBRACE  = 5'd24,
    KIND_RBRACE  = 5'd25,
    KIND_UNKNOWN = 5'd26
  } kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_INT  = 6'b000010,
    MODE_SYM  = 6'b000100,
    MODE_EQ   = 6'b001000,
    MODE_LT   = 6'b010000,
    MODE_GT   = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_mark;
  } in_beat_t;

  typedef struct packed {
    kind_e       token_kind;
    logic [30:0] int_value;
    logic [5:0]  text_length;
    logic [63:0] text_head;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_beat_t;

  // up to two tokens produced by one character
  typedef struct packed {
    logic [1:0] count;
    out_beat_t  tok0;
    out_beat_t  tok1;
  } tok_pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic kind_e single_op_kind(input logic [7:0] c);
    kind_e k;
    unique case (c)
      8'h3B:   k = KIND_SEMI;
      8'h26:   k = KIND_AND;
      8'h7C:   k = KIND_OR;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h25:   k = KIND_PERCENT;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/slt_lex.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// slt_lex
// Lexer state and token formation: one character per cycle while accept_i is high, zero to two tokens.
// ============================================================================
module slt_lex #(
  parameter int TEXT_MAX = slt_pkg::TEXT_MAX_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire slt_pkg::in_beat_t beat_i,
  output slt_pkg::tok_pair_t    pair_o
);
  import slt_pkg::*;

  localparam int LW      = $clog2(TEXT_MAX + 1);
  localparam int LenExtW = (LW > 6) ? LW : 6;

  mode_e          mode_q, mode_d;
  logic [30:0]    acc_q, acc_d;
  logic [LW-1:0]  len_q, len_d;
  logic [63:0]    head_q, head_d;
  logic [15:0]    line_q, line_d;

  logic [7:0]         c;
  logic [LW-1:0]      keep_len;
  logic [63:0]        keep_head;
  logic [34:0]        acc_wide;
  logic [30:0]        acc_next;
  logic [LenExtW-1:0] len_ext;
  logic [5:0]         len_field;
  kind_e              word_kind;
  out_beat_t          flush_tok, char_tok;
  logic               flush_emit, char_emit;

  assign c = beat_i.in_char;

  // append one character to the kept text
  always_comb begin
    keep_len  = len_q;
    keep_head = head_q;
    if (len_q < LW'(TEXT_MAX)) begin
      for (int i = 0; i < 8; i++) begin
        if (len_q == LW'(i)) keep_head[8*i +: 8] = c;
      end
      keep_len = LW'(len_q + 1'b1);
    end
  end

  // acc * 10 + digit, saturating
  assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, c[3:0]};
  assign acc_next = (acc_wide > {4'd0, INT_SAT}) ? INT_SAT : acc_wide[30:0];

  assign len_ext   = LenExtW'(len_q);
  assign len_field = (len_ext > LenExtW'(TEXT_CAP)) ? 6'(TEXT_CAP) : len_ext[5:0];

  always_comb begin
    priority if (len_q == LW'(2) && head_q == KW_IF)    word_kind = KIND_IF;
    else if     (len_q == LW'(4) && head_q == KW_ELSE)  word_kind = KIND_ELSE;
    else if     (len_q == LW'(5) && head_q == KW_WHILE) word_kind = KIND_WHILE;
    else if     (len_q == LW'(4) && head_q == KW_PUTI)  word_kind = KIND_PUTI;
    else if     (len_q == LW'(4) && head_q == KW_PUTC)  word_kind = KIND_PUTC;
    else                                                word_kind = KIND_SYM;
  end

  // token held back by the pending mode
  always_comb begin
    flush_tok             = '0;
    flush_tok.line_number = line_q;
    unique case (mode_q)
      MODE_INT: begin
        flush_tok.token_kind  = KIND_INT;
        flush_tok.int_value   = acc_q;
        flush_tok.text_length = len_field;
        flush_tok.text_head   = head_q;
      end
      MODE_SYM: begin
        flush_tok.token_kind  = word_kind;
        flush_tok.text_length = len_field;
        flush_tok.text_head   = head_q;
      end
      MODE_EQ: begin
        flush_tok.token_kind  = KIND_ASSIGN;
        flush_tok.text_length = 6'd1;
        flush_tok.text_head   = {56'd0, CH_EQ};
      end
      MODE_LT: begin
        flush_tok.token_kind  = KIND_LT;
        flush_tok.text_length = 6'd1;
        flush_tok.text_head   = {56'd0, CH_LT};
      end
      MODE_GT: begin
        flush_tok.token_kind  = KIND_GT;
        flush_tok.text_length = 6'd1;
        flush_tok.text_head   = {56'd0, CH_GT};
      end
      default: flush_tok.token_kind = KIND_END;
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    len_d      = len_q;
    head_d     = head_q;
    line_d     = line_q;
    flush_emit = 1'b0;
    char_emit  = 1'b0;
    char_tok             = '0;
    char_tok.token_kind  = KIND_END;
    char_tok.line_number = line_q;
    char_tok.last_of_run = 1'b1;
    if (accept_i) begin
      if (beat_i.end_mark) begin
        flush_emit = (mode_q != MODE_IDLE);
        char_emit  = 1'b1;
        mode_d     = MODE_IDLE;
        acc_d      = '0;
        len_d      = '0;
        head_d     = '0;
        line_d     = '0;
      end else if (mode_q == MODE_INT && is_digit(c)) begin
        acc_d  = acc_next;
        len_d  = keep_len;
        head_d = keep_head;
      end else if (mode_q == MODE_SYM && is_alpha(c)) begin
        len_d  = keep_len;
        head_d = keep_head;
      end else if ((mode_q == MODE_EQ || mode_q == MODE_LT || mode_q == MODE_GT) &&
                   c == CH_EQ) begin
        // two-character relational operator
        char_emit            = 1'b1;
        char_tok.text_length = 6'd2;
        mode_d               = MODE_IDLE;
        unique case (mode_q)
          MODE_EQ: begin
            char_tok.token_kind = KIND_EQ;
            char_tok.text_head  = {48'd0, CH_EQ, CH_EQ};
          end
          MODE_LT: begin
            char_tok.token_kind = KIND_LE;
            char_tok.text_head  = {48'd0, CH_EQ, CH_LT};
          end
          default: begin
            char_tok.token_kind = KIND_GE;
            char_tok.text_head  = {48'd0, CH_EQ, CH_GT};
          end
        endcase
      end else begin
        flush_emit = (mode_q != MODE_IDLE);
        mode_d     = MODE_IDLE;
        acc_d      = '0;
        len_d      = '0;
        head_d     = '0;
        priority if (is_space(c)) begin
          if (c == CH_NEWLINE && line_q != 16'hFFFF) line_d = line_q + 16'd1;
        end else if (is_digit(c)) begin
          mode_d = MODE_INT;
          acc_d  = {27'd0, c[3:0]};
          len_d  = LW'(1);
          head_d = {56'd0, c};
        end else if (is_alpha(c)) begin
          mode_d = MODE_SYM;
          len_d  = LW'(1);
          head_d = {56'd0, c};
        end else if (c == CH_EQ) begin
          mode_d = MODE_EQ;
        end else if (c == CH_LT) begin
          mode_d = MODE_LT;
        end else if (c == CH_GT) begin
          mode_d = MODE_GT;
        end else begin
          char_emit            = 1'b1;
          char_tok.token_kind  = single_op_kind(c);
          char_tok.text_length = 6'd1;
          char_tok.text_head   = {56'd0, c};
        end
      end
    end
  end

  // pending token goes first when both are produced
  always_comb begin
    pair_o       = '0;
    pair_o.count = {1'b0, flush_emit} + {1'b0, char_emit};
    pair_o.tok0  = flush_emit ? flush_tok : char_tok;
    pair_o.tok0.last_of_run = !(flush_emit && char_emit);
    pair_o.tok1  = char_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      len_q  <= '0;
      head_q <= '0;
      line_q <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
      head_q <= head_d;
      line_q <= line_d;
    end
  end

  // no text is held outside a number or word
  a_text_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE || mode_q == MODE_EQ || mode_q == MODE_LT || mode_q == MODE_GT)
      |-> (len_q == '0 && head_q == '0 && acc_q == '0))
    else $error("text held while no number or word pending");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && beat_i.end_mark) |=> (line_q == '0 && mode_q == MODE_IDLE))
    else $error("end mark did not clear line count and mode");

  a_pair_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_o.count == 2'd2) |-> (mode_q != MODE_IDLE))
    else $error("two tokens without a pending token");

endmodule
`default_nettype wire

// ===== hdl/slt_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// slt_fifo
// Token queue: takes up to two tokens per cycle, hands out one beat per cycle while out_stall_i is low.
// ============================================================================
module slt_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire slt_pkg::tok_pair_t push_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output slt_pkg::out_beat_t      out_beat_o
);
  import slt_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  out_beat_t       mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = mem_q[rd_ptr_q];
  // room for a two-token character is needed before the next one is taken
  assign full_o      = (count_q > CntW'(FIFO_DEPTH - 2));

  // pointers wrap on their own: depth is a power of two
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.count == 2'd2) mem_q[PtrW'(wr_ptr_q + 1'b1)] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FIFO_DEPTH))
    else $error("token queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (count_q <= CntW'(FIFO_DEPTH - 2)))
    else $error("tokens pushed without room for two");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count wrong after pop");

endmodule
`default_nettype wire

// ===== hdl/small_language_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// small_language_tokenizer
// Streaming lexer: one source character per beat in, tokens out.
// ============================================================================
// One character (or the end mark) is taken per cycle whenever in_stall_o is
// low; the lexer state updates in that same cycle and the zero, one or two
// tokens the character completes are written into a four-entry token queue,
// whose registered head entry drives the output. Tokens leave at one per
// cycle while out_stall_i is low, which is what sets the rate: a run of
// characters that each produce at most one token streams at one per cycle,
// while characters that produce two tokens (a pending token plus a new one,
// or the end mark behind a pending token) push two entries and in_stall_o
// rises whenever fewer than two queue entries are free.
// Whitespace is skipped and newlines are counted (saturating at 65535);
// digit runs make integer tokens saturating at 2147483647; letter runs make
// symbol or keyword tokens; text keeps up to TEXT_MAX characters and reports
// the first eight, first character in the low byte. last_of_run marks the
// final token caused by one character. The end mark flushes any pending
// token, emits an end token and clears the line count.
// ============================================================================
module small_language_tokenizer #(
  parameter int TEXT_MAX = slt_pkg::TEXT_MAX_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire slt_pkg::in_beat_t in_beat_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output slt_pkg::out_beat_t     out_beat_o
);
  import slt_pkg::*;

  logic      in_accept;
  logic      queue_full;
  tok_pair_t tok_pair;

  // queue fullness is registered, so stall has no path from the input side
  assign in_stall_o = queue_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  slt_lex #(
    .TEXT_MAX (TEXT_MAX)
  ) u_lex (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .beat_i   (in_beat_i),
    .pair_o   (tok_pair)
  );

  slt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tok_pair),
    .full_o      (queue_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire
